// ===== hw/rtl/sbcc_pkg.sv =====
package sbcc_pkg;

    localparam int MAX_OBSTACLES = 64;
    localparam int SLOT_W = 6;
    localparam int COUNT_W = 7;
    localparam int MARGIN_W = 31;
    localparam int COORD_W = 32;
    localparam int SUM_W = 35;
    localparam int PROD_W = 72;
    localparam int TDATA_W = 200;

    localparam logic [1:0] REG_COUNT = 2'd0;
    localparam logic [1:0] REG_MARGIN = 2'd1;

    typedef struct packed {
        logic signed [COORD_W-1:0] lo_x;
        logic signed [COORD_W-1:0] lo_y;
        logic signed [COORD_W-1:0] lo_z;
        logic signed [COORD_W-1:0] hi_x;
        logic signed [COORD_W-1:0] hi_y;
        logic signed [COORD_W-1:0] hi_z;
    } box_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] d_x;
        logic signed [SUM_W-1:0] d_y;
        logic signed [SUM_W-1:0] d_z;
        logic signed [SUM_W-1:0] s_x;
        logic signed [SUM_W-1:0] s_y;
        logic signed [SUM_W-1:0] s_z;
    } seg_t;

    // one box test moving down the cell row
    typedef struct packed {
        logic                   valid;
        logic                   last;
        logic                   hit;
        logic signed [SUM_W-1:0] t_x;
        logic signed [SUM_W-1:0] t_y;
        logic signed [SUM_W-1:0] t_z;
        logic signed [SUM_W-1:0] h_x;
        logic signed [SUM_W-1:0] h_y;
        logic signed [SUM_W-1:0] h_z;
    } tok_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_OUT
    } state_t;

    function automatic logic signed [SUM_W-1:0] abs_s(input logic signed [SUM_W-1:0] v);
        abs_s = v[SUM_W-1] ? -v : v;
    endfunction

endpackage

// ===== hw/rtl/sbcc_face_cell.sv =====
module sbcc_face_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sbcc_pkg::seg_t                  seg,
    input  sbcc_pkg::box_t                  box,
    input  logic [sbcc_pkg::MARGIN_W-1:0]   margin,
    input  logic                            in_valid,
    input  logic                            in_last,
    output sbcc_pkg::tok_t                  tok
);
    import sbcc_pkg::*;

    tok_t tok_reg;
    tok_t tok_next;
    logic signed [SUM_W-1:0] m2;
    logic ok_x, ok_y, ok_z;

    always_comb
    begin
        m2 = SUM_W'({margin, 1'b0});
        tok_next.valid = in_valid;
        tok_next.last = in_last;
        tok_next.t_x = seg.s_x - (SUM_W'(box.lo_x) + SUM_W'(box.hi_x));
        tok_next.t_y = seg.s_y - (SUM_W'(box.lo_y) + SUM_W'(box.hi_y));
        tok_next.t_z = seg.s_z - (SUM_W'(box.lo_z) + SUM_W'(box.hi_z));
        tok_next.h_x = (SUM_W'(box.hi_x) - SUM_W'(box.lo_x)) + m2;
        tok_next.h_y = (SUM_W'(box.hi_y) - SUM_W'(box.lo_y)) + m2;
        tok_next.h_z = (SUM_W'(box.hi_z) - SUM_W'(box.lo_z)) + m2;
        ok_x = !(abs_s(tok_next.t_x) > tok_next.h_x + abs_s(seg.d_x));
        ok_y = !(abs_s(tok_next.t_y) > tok_next.h_y + abs_s(seg.d_y));
        ok_z = !(abs_s(tok_next.t_z) > tok_next.h_z + abs_s(seg.d_z));
        tok_next.hit = ok_x && ok_y && ok_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    assign tok = tok_reg;

endmodule

// ===== hw/rtl/sbcc_edge_cell.sv =====
module sbcc_edge_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          axis,
    input  sbcc_pkg::seg_t      seg,
    input  sbcc_pkg::tok_t      tok_in,
    output sbcc_pkg::tok_t      tok_out
);
    import sbcc_pkg::*;

    // two-stage cell: products, then compare
    tok_t tok1_reg;
    tok_t tok_reg;
    tok_t tok_next;
    logic signed [PROD_W-1:0] rad1_reg, rad2_reg, dst1_reg, dst2_reg;
    logic signed [SUM_W-1:0] ha, hb, ta, tb, da, db;
    logic signed [PROD_W:0] rad, dst, dabs;

    always_comb
    begin
        case (axis)
            2'd0:
            begin
                ha = tok_in.h_y; hb = tok_in.h_z; ta = tok_in.t_y; tb = tok_in.t_z;
                da = seg.d_y; db = seg.d_z;
            end
            2'd1:
            begin
                ha = tok_in.h_z; hb = tok_in.h_x; ta = tok_in.t_z; tb = tok_in.t_x;
                da = seg.d_z; db = seg.d_x;
            end
            default:
            begin
                ha = tok_in.h_x; hb = tok_in.h_y; ta = tok_in.t_x; tb = tok_in.t_y;
                da = seg.d_x; db = seg.d_y;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok1_reg <= '0;
            tok_reg <= '0;
        end
        else
        begin
            tok1_reg <= tok_in;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad1_reg <= PROD_W'(ha) * PROD_W'(abs_s(db));
        rad2_reg <= PROD_W'(hb) * PROD_W'(abs_s(da));
        dst1_reg <= PROD_W'(ta) * PROD_W'(db);
        dst2_reg <= PROD_W'(tb) * PROD_W'(da);
    end

    always_comb
    begin
        tok_next = tok1_reg;
        rad = (PROD_W+1)'(rad1_reg) + (PROD_W+1)'(rad2_reg);
        dst = (PROD_W+1)'(dst1_reg) - (PROD_W+1)'(dst2_reg);
        dabs = dst[PROD_W] ? -dst : dst;
        tok_next.hit = tok1_reg.hit && !(dabs > rad);
    end

    assign tok_out = tok_reg;

endmodule

// ===== hw/rtl/segment_box_collision_check_unit.sv =====
// segment versus obstacle box collision check
// s_axis: tuser = mode (0 load box, 1 query), tdata = slot, first_x/y/z,
// second_x/y/z. a load item writes one slot and gives no result.
// m_axis: tdata[0] = path_clear, one item per query.
// apb: register 0 obstacle_count (0x0), register 1 margin (0x4).
// a query streams boxes from the table, one per cycle, through a row of
// cells: a face cell (three face axes) then an edge cell for each
// cross-product axis, each with a product and a compare stage. the box table read is registered.
// a query with an empty table skips the walk and goes straight to the
// output register. a query holds the input until its result is loaded
// there; a load does not. one query is in flight at a time; the walk keeps
// going after a hit but the answer is the and of all tests.
// the result goes to an output register; while it waits there loads and
// the next query are still accepted, and a query that finishes before the
// register is free holds the input until the receiver takes the result.
// reset clears control and registers, not the table.
module segment_box_collision_check_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [sbcc_pkg::TDATA_W-1:0] s_axis_tdata,  // slot, first_x/y/z, second_x/y/z, zero fill
    input  logic                         s_axis_tuser,  // mode
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,  // path_clear, zero fill
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import sbcc_pkg::*;

    logic [COUNT_W-1:0]  count_reg;
    logic [MARGIN_W-1:0] margin_reg;
    state_t state_reg, state_next;
    logic [COUNT_W-1:0] idx_reg, idx_next, n_eff;
    logic clear_reg, clear_next;
    logic res_reg, res_next;
    logic out_valid_reg, out_data_reg;
    logic out_load;
    seg_t seg_reg;
    box_t mem [MAX_OBSTACLES];
    box_t rd_reg;
    logic rv_reg, rl_reg;
    logic issue, issue_last;
    tok_t t0, t1, t2, t3;
    logic accept;
    box_t wbox;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            margin_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2:2])
                REG_COUNT[0:0]: count_reg <= pwdata[COUNT_W-1:0];
                default: margin_reg <= pwdata[MARGIN_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2:2])
            REG_COUNT[0:0]: prdata = 32'(count_reg);
            default: prdata = 32'(margin_reg);
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign n_eff = (count_reg > COUNT_W'(MAX_OBSTACLES)) ? COUNT_W'(MAX_OBSTACLES) : count_reg;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        wbox.lo_x = s_axis_tdata[37:6];
        wbox.lo_y = s_axis_tdata[69:38];
        wbox.lo_z = s_axis_tdata[101:70];
        wbox.hi_x = s_axis_tdata[133:102];
        wbox.hi_y = s_axis_tdata[165:134];
        wbox.hi_z = s_axis_tdata[197:166];
    end

    always_ff @(posedge clk)
    begin
        if (accept && !s_axis_tuser)
            mem[s_axis_tdata[SLOT_W-1:0]] <= wbox;
        rd_reg <= mem[idx_reg[SLOT_W-1:0]];
        if (accept && s_axis_tuser)
        begin
            seg_reg.d_x <= SUM_W'(wbox.hi_x) - SUM_W'(wbox.lo_x);
            seg_reg.d_y <= SUM_W'(wbox.hi_y) - SUM_W'(wbox.lo_y);
            seg_reg.d_z <= SUM_W'(wbox.hi_z) - SUM_W'(wbox.lo_z);
            seg_reg.s_x <= SUM_W'(wbox.hi_x) + SUM_W'(wbox.lo_x);
            seg_reg.s_y <= SUM_W'(wbox.hi_y) + SUM_W'(wbox.lo_y);
            seg_reg.s_z <= SUM_W'(wbox.hi_z) + SUM_W'(wbox.lo_z);
        end
    end

    assign issue = (state_reg == ST_WALK) && (idx_reg < n_eff);
    assign issue_last = issue && (idx_reg + 1'b1 == n_eff);

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        clear_next = clear_reg;
        res_next = res_reg;
        // hits can reach the row end while the walk is still issuing
        if (t3.valid && t3.hit)
            clear_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && s_axis_tuser)
                begin
                    idx_next = '0;
                    clear_next = 1'b1;
                    state_next = (n_eff == '0) ? ST_OUT : ST_WALK;
                    res_next = 1'b1;
                end
            end
            ST_WALK:
            begin
                idx_next = idx_reg + 1'b1;
                if (issue_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (t3.valid && t3.last)
                begin
                    res_next = clear_reg && !t3.hit;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            clear_reg <= 1'b1;
            res_reg <= 1'b1;
            rv_reg <= 1'b0;
            rl_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            clear_reg <= clear_next;
            res_reg <= res_next;
            rv_reg <= issue;
            rl_reg <= issue_last;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg <= res_reg;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    sbcc_face_cell u_face (
        .clk(clk), .rst_n(rst_n), .seg(seg_reg), .box(rd_reg), .margin(margin_reg),
        .in_valid(rv_reg), .in_last(rl_reg), .tok(t0)
    );
    sbcc_edge_cell u_edge_x (
        .clk(clk), .rst_n(rst_n), .axis(2'd0), .seg(seg_reg), .tok_in(t0), .tok_out(t1)
    );
    sbcc_edge_cell u_edge_y (
        .clk(clk), .rst_n(rst_n), .axis(2'd1), .seg(seg_reg), .tok_in(t1), .tok_out(t2)
    );
    sbcc_edge_cell u_edge_z (
        .clk(clk), .rst_n(rst_n), .axis(2'd2), .seg(seg_reg), .tok_in(t2), .tok_out(t3)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {7'd0, out_data_reg};

endmodule
